// ===== rtl/lruc_pkg.sv =====
`timescale 1ns / 1ps

package lruc_pkg;

   localparam int KEY_W           = 64;
   localparam int COST_W          = 32;
   localparam int CAP_W           = 6;
   localparam int ADDR_W          = 3;
   localparam int DATA_W          = 32;
   localparam int MAX_ENTRIES_DEF = 32;

   localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(32);
   localparam logic [COST_W-1:0] HIT_COST  = COST_W'(1);
   localparam logic [COST_W-1:0] MISS_COST = COST_W'(5);
   localparam logic [COST_W-1:0] COST_MAX  = {COST_W{1'b1}};

   // register index, taken from paddr[2]
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   // per-cell control from the top level
   typedef struct packed {
      logic compare;   // register the tag match
      logic update;    // apply shift / drop this cycle
      logic shift;     // take key and valid from the neighbor above
      logic drop;      // clear valid (entry beyond capacity on a miss)
   } cell_ctl_type;

endpackage

// ===== rtl/lru_cache_hit_cost_top.sv =====
`timescale 1ns / 1ps

// channel    | handshake                           | payload
// -----------+-------------------------------------+------------------------------
// request    | start / busy, taken: start & !busy  | req_city_key[63:0]
// response   | rsp_valid strobe, one cycle         | rsp_hit, rsp_total_cost[31:0]
// config     | APB: psel penable pwrite, pready=1  | paddr[2:0], pwdata, prdata
//
// Each word passes through the taking cycle, the parallel tag compare in
// every cell, and the recency shift along the cell chain; busy is high
// during the compare and the shift. The response strobe shows in the cycle
// after the update and a new word may be taken in that same cycle. Reset
// clears the cache (all cells invalid), the cost sum and the capacity
// register (back to 32). The receiver cannot stall.

module lru_cache_hit_cost_top
   import lruc_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request
   input  logic              start,
   output logic              busy,
   input  logic [KEY_W-1:0]  req_city_key,
   // response
   output logic              rsp_valid,
   output logic              rsp_hit,
   output logic [COST_W-1:0] rsp_total_cost,
   // configuration
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   // Cells are kept in recency order: cell 0 is most recent. Valid cells
   // always form a prefix of the chain.

   state_type         state_ff, state_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [COST_W-1:0] rsp_cost_ff, rsp_cost_in;

   logic [KEY_W-1:0]       cell_key   [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] cell_valid;
   logic [MAX_ENTRIES-1:0] cell_match;
   cell_ctl_type           cell_ctl   [MAX_ENTRIES];

   logic              cache_on;
   logic              hit;
   logic [IDX_W-1:0]  hit_pos;
   logic              do_compare;
   logic              do_update;
   logic [COST_W:0]   cost_sum;
   logic              csr_write;

   function automatic logic [IDX_W-1:0] encode_pos(input logic [MAX_ENTRIES-1:0] onehot);
      logic [IDX_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (onehot[i]) begin
            pos = pos | IDX_W'(i);
         end
      end
      return pos;
   endfunction

   // ---------------- configuration ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && (paddr[2] == REG_CAPACITY)) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(capacity_ff) : '0;

   // ---------------- lookup / update ----------------
   // capacity zero: every word counts as a miss, no insert, cell keys and valids untouched
   assign cache_on = (capacity_ff != '0);
   assign hit      = cache_on && (|cell_match);
   assign hit_pos  = encode_pos(cell_match);

   assign cost_sum = {1'b0, cost_ff} + {1'b0, (hit ? HIT_COST : MISS_COST)};

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      cost_in      = cost_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_cost_in  = rsp_cost_ff;
      do_compare   = 1'b0;
      do_update    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in   = req_city_key;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            do_compare = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            do_update    = cache_on;
            cost_in      = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
            rsp_valid_in = 1'b1;
            rsp_hit_in   = hit;
            rsp_cost_in  = cost_in;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // ---------------- cell chain ----------------
   // hit: cells up to the hit position shift down, the key lands in cell 0.
   // miss: everything shifts down, cells at or beyond capacity are dropped.
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [KEY_W-1:0] prev_key;
      logic             prev_valid;

      if (i == 0) begin : g_head
         assign prev_key   = key_ff;
         assign prev_valid = 1'b1;
      end else begin : g_link
         assign prev_key   = cell_key[i-1];
         assign prev_valid = cell_valid[i-1];
      end

      always_comb begin
         cell_ctl[i].compare = do_compare;
         cell_ctl[i].update  = do_update;
         cell_ctl[i].shift   = hit ? (32'(i) <= 32'(hit_pos)) : 1'b1;
         cell_ctl[i].drop    = !hit && (32'(i) >= 32'(capacity_ff));
      end

      lruc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[i]),
         .lookup_key (key_ff),
         .prev_key   (prev_key),
         .prev_valid (prev_valid),
         .key_q      (cell_key[i]),
         .valid_q    (cell_valid[i]),
         .match_q    (cell_match[i])
      );
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAP_RESET;
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         cost_ff      <= cost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_cost_ff <= rsp_cost_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_total_cost = rsp_cost_ff;

endmodule

// ===== rtl/lruc_cell.sv =====
`timescale 1ns / 1ps

module lruc_cell
   import lruc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cell_ctl_type     ctl,
   input  logic [KEY_W-1:0] lookup_key,
   input  logic [KEY_W-1:0] prev_key,
   input  logic             prev_valid,
   output logic [KEY_W-1:0] key_q,
   output logic             valid_q,
   output logic             match_q
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic             valid_ff;
   logic             valid_in;
   logic             match_ff;
   logic             match_in;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      match_in = match_ff;
      if (ctl.compare) begin
         match_in = valid_ff && (key_ff == lookup_key);
      end
      if (ctl.update) begin
         if (ctl.shift) begin
            key_in   = prev_key;
            valid_in = prev_valid;
         end
         if (ctl.drop) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   // key storage needs no reset: reads are gated by valid
   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_q   = key_ff;
   assign valid_q = valid_ff;
   assign match_q = match_ff;

endmodule

// ===== rtl/lruc_checker.sv =====
`timescale 1ns / 1ps

module lruc_checker
   import lruc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic              rsp_hit,
   input logic [COST_W-1:0] rsp_total_cost,
   input logic              pready
);

   // a taken word makes the block busy next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a word was taken");

   // every taken word gets its response once the compare and the update are done
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##2 rsp_valid)
      else $error("response strobe missing three cycles after a take");

   // the response shows only while the block is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   // a miss always adds five, so the running sum is at least that
   a_miss_cost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_total_cost >= MISS_COST))
      else $error("miss reported with a cost below the miss cost");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready dropped");

endmodule

bind lru_cache_hit_cost_top lruc_checker u_lruc_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_hit        (rsp_hit),
   .rsp_total_cost (rsp_total_cost),
   .pready         (pready)
);
